// ===== design/tcl_pkg.sv =====
package tcl_pkg;

    // Default coordinate width: signed Q8.8 landmarks and positions.
    localparam int COORD_WIDTH_DEF = 16;

endpackage

// ===== design/two_circle_localizer.sv =====
// Two-circle localizer: position fix from two ranged landmarks.
// Input beat: two landmark centers, range to each, previous position.
// A beat is taken on a rising edge with start high and busy low; busy is
// low whenever the block is out of reset, so a new beat may come every cycle.
// Output beat: o_pos_x, o_pos_y, o_found, valid for one cycle while o_strobe
// is high. The receiver cannot stall; results simply appear in order.
// Throughput: one beat per clock. Each beat passes through the integer square
// root (one root bit per stage, 2*COORD_WIDTH stages) and the four rounding
// dividers (COORD_WIDTH+1 stages, one quotient bit each).
// If the circles do not meet (coincident centers, too far apart, or nested)
// the previous position comes back with o_found low. Otherwise the nearer of
// the two intersection points is returned (second point on a tie), each
// coordinate saturated to the signed coordinate range.
// Reset (synchronous, active low) flushes every stage's valid bit; items in
// flight are dropped and busy is high while reset is held.
module two_circle_localizer #(
    parameter int COORD_WIDTH = tcl_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_first_center_x,
    input  logic signed [COORD_WIDTH-1:0] i_first_center_y,
    input  logic        [COORD_WIDTH-2:0] i_first_range,
    input  logic signed [COORD_WIDTH-1:0] i_second_center_x,
    input  logic signed [COORD_WIDTH-1:0] i_second_center_y,
    input  logic        [COORD_WIDTH-2:0] i_second_range,
    input  logic signed [COORD_WIDTH-1:0] i_prev_x,
    input  logic signed [COORD_WIDTH-1:0] i_prev_y,
    output logic                          o_strobe,
    output logic signed [COORD_WIDTH-1:0] o_pos_x,
    output logic signed [COORD_WIDTH-1:0] o_pos_y,
    output logic                          o_found
);

    localparam int CW     = COORD_WIDTH;
    localparam int RW     = CW - 1;        // range
    localparam int DW     = CW + 1;        // center difference
    localparam int SQW    = 2 * CW;        // (r1+r2)^2, K factors, root
    localparam int DFW    = 2 * CW - 2;    // (r1-r2)^2, r^2
    localparam int DDW    = 2 * CW + 2;    // D and N
    localparam int KW     = 4 * CW;        // root argument
    localparam int PW     = 3 * CW + 3;    // numerators
    localparam int QW     = CW + 1;        // quotient magnitude
    localparam int DENW   = 2 * CW + 3;    // 2D
    localparam int PTW    = CW + 3;        // candidate point
    localparam int EW     = CW + 4;        // offset from previous position
    localparam int E2W    = 2 * CW + 7;    // squared offset
    localparam int DSW    = 2 * CW + 8;    // squared distance
    localparam int SQ_LAT = KW / 2;
    localparam int DV_LAT = QW;
    localparam int LATENCY = 13 + SQ_LAT + DV_LAT;

    typedef struct packed {
        logic signed [CW-1:0]  x1;
        logic signed [CW-1:0]  y1;
        logic signed [CW-1:0]  px;
        logic signed [CW-1:0]  py;
        logic signed [DW-1:0]  dx;
        logic signed [DW-1:0]  dy;
        logic        [DDW-1:0] dd;
        logic signed [DDW-1:0] n;
        logic                  ok;
    } t_sq_side;

    typedef struct packed {
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] y1;
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic                 ok;
        logic                 neg_ax;
        logic                 neg_ay;
        logic                 neg_bx;
        logic                 neg_by;
    } t_dv_side;

    logic accept;
    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    // ---- stage 1: differences of centers, sum and gap of ranges
    logic                  r1_vld;
    logic signed [CW-1:0]  r1_x1, r1_y1, r1_px, r1_py;
    logic signed [DW-1:0]  r1_dx, r1_dy;
    logic        [CW-1:0]  r1_rs;
    logic        [RW-1:0]  r1_rd, r1_ra, r1_rb;

    always_ff @(posedge i_clk) begin
        r1_x1 <= i_first_center_x;
        r1_y1 <= i_first_center_y;
        r1_px <= i_prev_x;
        r1_py <= i_prev_y;
        r1_dx <= DW'(i_second_center_x) - DW'(i_first_center_x);
        r1_dy <= DW'(i_second_center_y) - DW'(i_first_center_y);
        r1_rs <= CW'(i_first_range) + CW'(i_second_range);
        r1_rd <= (i_first_range >= i_second_range) ? i_first_range - i_second_range
                                                   : i_second_range - i_first_range;
        r1_ra <= i_first_range;
        r1_rb <= i_second_range;
    end

    // ---- stage 2: squares
    logic                  r2_vld;
    logic signed [CW-1:0]  r2_x1, r2_y1, r2_px, r2_py;
    logic signed [DW-1:0]  r2_dx, r2_dy;
    logic        [2*CW:0]  r2_dx2, r2_dy2;
    logic        [SQW-1:0] r2_sum2;
    logic        [DFW-1:0] r2_dif2, r2_ra2, r2_rb2;
    logic signed [DDW-1:0] c2_dx2, c2_dy2;

    assign c2_dx2 = r1_dx * r1_dx;
    assign c2_dy2 = r1_dy * r1_dy;

    always_ff @(posedge i_clk) begin
        r2_x1   <= r1_x1;
        r2_y1   <= r1_y1;
        r2_px   <= r1_px;
        r2_py   <= r1_py;
        r2_dx   <= r1_dx;
        r2_dy   <= r1_dy;
        r2_dx2  <= c2_dx2[2*CW:0];
        r2_dy2  <= c2_dy2[2*CW:0];
        r2_sum2 <= SQW'(r1_rs) * SQW'(r1_rs);
        r2_dif2 <= DFW'(r1_rd) * DFW'(r1_rd);
        r2_ra2  <= DFW'(r1_ra) * DFW'(r1_ra);
        r2_rb2  <= DFW'(r1_rb) * DFW'(r1_rb);
    end

    // ---- stage 3: D and r1^2 - r2^2
    logic                  r3_vld;
    logic signed [CW-1:0]  r3_x1, r3_y1, r3_px, r3_py;
    logic signed [DW-1:0]  r3_dx, r3_dy;
    logic        [DDW-1:0] r3_dd;
    logic signed [DFW:0]   r3_rdf;
    logic        [SQW-1:0] r3_sum2;
    logic        [DFW-1:0] r3_dif2;

    always_ff @(posedge i_clk) begin
        r3_x1   <= r2_x1;
        r3_y1   <= r2_y1;
        r3_px   <= r2_px;
        r3_py   <= r2_py;
        r3_dx   <= r2_dx;
        r3_dy   <= r2_dy;
        r3_dd   <= DDW'(r2_dx2) + DDW'(r2_dy2);
        r3_rdf  <= $signed({1'b0, r2_ra2}) - $signed({1'b0, r2_rb2});
        r3_sum2 <= r2_sum2;
        r3_dif2 <= r2_dif2;
    end

    // ---- stage 4: intersection test, root factors, N
    logic                  r4_vld;
    logic signed [CW-1:0]  r4_x1, r4_y1, r4_px, r4_py;
    logic signed [DW-1:0]  r4_dx, r4_dy;
    logic        [DDW-1:0] r4_dd;
    logic signed [DDW-1:0] r4_n;
    logic        [SQW-1:0] r4_a, r4_b;
    logic                  r4_ok;
    logic                  c4_ok;

    assign c4_ok = (r3_dd != '0) && (r3_dd <= DDW'(r3_sum2)) && (r3_dd >= DDW'(r3_dif2));

    always_ff @(posedge i_clk) begin
        r4_x1 <= r3_x1;
        r4_y1 <= r3_y1;
        r4_px <= r3_px;
        r4_py <= r3_py;
        r4_dx <= r3_dx;
        r4_dy <= r3_dy;
        r4_dd <= r3_dd;
        r4_n  <= $signed(r3_dd) + DDW'(r3_rdf);
        r4_a  <= c4_ok ? SQW'(DDW'(r3_sum2) - r3_dd) : '0;
        r4_b  <= c4_ok ? SQW'(r3_dd - DDW'(r3_dif2)) : '0;
        r4_ok <= c4_ok;
    end

    // ---- stage 5: K = a*b, zero when circles miss
    logic                  r5_vld;
    logic        [KW-1:0]  r5_k;
    t_sq_side              r5_side;

    always_ff @(posedge i_clk) begin
        r5_k    <= KW'(r4_a) * KW'(r4_b);
        r5_side <= '{x1: r4_x1, y1: r4_y1, px: r4_px, py: r4_py, dx: r4_dx, dy: r4_dy,
                     dd: r4_dd, n: r4_n, ok: r4_ok};
    end

    // ---- integer square root, side data rides a matched delay line
    logic            sq_vld;
    logic [SQW-1:0]  sq_root;
    t_sq_side        r_sq_side [SQ_LAT];

    tcl_isqrt #(
        .IN_W (KW)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r5_vld),
        .i_value (r5_k),
        .o_valid (sq_vld),
        .o_root  (sq_root)
    );

    always_ff @(posedge i_clk) begin
        r_sq_side[0] <= r5_side;
        for (int i = 1; i < SQ_LAT; i++) begin
            r_sq_side[i] <= r_sq_side[i-1];
        end
    end

    // ---- stage 6: the four products dx*N, dy*S, dy*N, dx*S
    t_sq_side              sqs;
    logic signed [SQW:0]   c6_s;
    logic                  r6_vld;
    logic signed [PW-1:0]  r6_dxn, r6_dys, r6_dyn, r6_dxs;
    logic signed [CW-1:0]  r6_x1, r6_y1, r6_px, r6_py;
    logic        [DDW-1:0] r6_dd;
    logic                  r6_ok;

    assign sqs  = r_sq_side[SQ_LAT-1];
    assign c6_s = $signed({1'b0, sq_root});

    always_ff @(posedge i_clk) begin
        r6_dxn <= PW'(sqs.dx) * PW'(sqs.n);
        r6_dys <= PW'(sqs.dy) * PW'(c6_s);
        r6_dyn <= PW'(sqs.dy) * PW'(sqs.n);
        r6_dxs <= PW'(sqs.dx) * PW'(c6_s);
        r6_x1  <= sqs.x1;
        r6_y1  <= sqs.y1;
        r6_px  <= sqs.px;
        r6_py  <= sqs.py;
        r6_dd  <= sqs.dd;
        r6_ok  <= sqs.ok;
    end

    // ---- stage 7: numerators of both points
    logic                  r7_vld;
    logic signed [PW-1:0]  r7_nax, r7_nay, r7_nbx, r7_nby;
    logic signed [CW-1:0]  r7_x1, r7_y1, r7_px, r7_py;
    logic        [DDW-1:0] r7_dd;
    logic                  r7_ok;

    always_ff @(posedge i_clk) begin
        r7_nax <= r6_dxn + r6_dys;
        r7_nbx <= r6_dxn - r6_dys;
        r7_nay <= r6_dyn - r6_dxs;
        r7_nby <= r6_dyn + r6_dxs;
        r7_x1  <= r6_x1;
        r7_y1  <= r6_y1;
        r7_px  <= r6_px;
        r7_py  <= r6_py;
        r7_dd  <= r6_dd;
        r7_ok  <= r6_ok;
    end

    // ---- stage 8: |num| + D, so floor(.../2D) rounds half away from zero
    logic                  r8_vld;
    logic [PW-1:0]         r8_mag_ax, r8_mag_ay, r8_mag_bx, r8_mag_by;
    logic [DENW-1:0]       r8_den;
    t_dv_side              r8_side;
    logic [PW-1:0]         c8_dd;

    assign c8_dd = PW'(r7_dd);

    always_ff @(posedge i_clk) begin
        r8_mag_ax <= r7_nax[PW-1] ? c8_dd - $unsigned(r7_nax) : $unsigned(r7_nax) + c8_dd;
        r8_mag_ay <= r7_nay[PW-1] ? c8_dd - $unsigned(r7_nay) : $unsigned(r7_nay) + c8_dd;
        r8_mag_bx <= r7_nbx[PW-1] ? c8_dd - $unsigned(r7_nbx) : $unsigned(r7_nbx) + c8_dd;
        r8_mag_by <= r7_nby[PW-1] ? c8_dd - $unsigned(r7_nby) : $unsigned(r7_nby) + c8_dd;
        r8_den    <= {r7_dd, 1'b0};
        r8_side   <= '{x1: r7_x1, y1: r7_y1, px: r7_px, py: r7_py, ok: r7_ok,
                       neg_ax: r7_nax[PW-1], neg_ay: r7_nay[PW-1],
                       neg_bx: r7_nbx[PW-1], neg_by: r7_nby[PW-1]};
    end

    // ---- four dividers by 2D
    logic [3:0]    dv_vld;
    logic [QW-1:0] q_ax, q_ay, q_bx, q_by;
    t_dv_side      r_dv_side [DV_LAT];

    tcl_rdiv #(.NUM_W(PW), .DEN_W(DENW), .Q_W(QW)) u_div_ax (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (r8_vld),
        .i_num (r8_mag_ax), .i_den (r8_den), .o_valid (dv_vld[0]), .o_quo (q_ax)
    );
    tcl_rdiv #(.NUM_W(PW), .DEN_W(DENW), .Q_W(QW)) u_div_ay (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (r8_vld),
        .i_num (r8_mag_ay), .i_den (r8_den), .o_valid (dv_vld[1]), .o_quo (q_ay)
    );
    tcl_rdiv #(.NUM_W(PW), .DEN_W(DENW), .Q_W(QW)) u_div_bx (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (r8_vld),
        .i_num (r8_mag_bx), .i_den (r8_den), .o_valid (dv_vld[2]), .o_quo (q_bx)
    );
    tcl_rdiv #(.NUM_W(PW), .DEN_W(DENW), .Q_W(QW)) u_div_by (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (r8_vld),
        .i_num (r8_mag_by), .i_den (r8_den), .o_valid (dv_vld[3]), .o_quo (q_by)
    );

    always_ff @(posedge i_clk) begin
        r_dv_side[0] <= r8_side;
        for (int i = 1; i < DV_LAT; i++) begin
            r_dv_side[i] <= r_dv_side[i-1];
        end
    end

    // ---- stage 9: candidate points
    t_dv_side             dvs;
    logic signed [QW:0]   c9_ax, c9_ay, c9_bx, c9_by;
    logic                 r9_vld;
    logic signed [PTW-1:0] r9_ax, r9_ay, r9_bx, r9_by;
    logic signed [CW-1:0] r9_px, r9_py;
    logic                 r9_ok;

    assign dvs   = r_dv_side[DV_LAT-1];
    assign c9_ax = dvs.neg_ax ? -$signed({1'b0, q_ax}) : $signed({1'b0, q_ax});
    assign c9_ay = dvs.neg_ay ? -$signed({1'b0, q_ay}) : $signed({1'b0, q_ay});
    assign c9_bx = dvs.neg_bx ? -$signed({1'b0, q_bx}) : $signed({1'b0, q_bx});
    assign c9_by = dvs.neg_by ? -$signed({1'b0, q_by}) : $signed({1'b0, q_by});

    always_ff @(posedge i_clk) begin
        r9_ax <= PTW'(dvs.x1) + PTW'(c9_ax);
        r9_ay <= PTW'(dvs.y1) + PTW'(c9_ay);
        r9_bx <= PTW'(dvs.x1) + PTW'(c9_bx);
        r9_by <= PTW'(dvs.y1) + PTW'(c9_by);
        r9_px <= dvs.px;
        r9_py <= dvs.py;
        r9_ok <= dvs.ok;
    end

    // ---- stage 10: offsets from previous position
    logic                  r10_vld;
    logic signed [EW-1:0]  r10_eax, r10_eay, r10_ebx, r10_eby;
    logic signed [PTW-1:0] r10_ax, r10_ay, r10_bx, r10_by;
    logic signed [CW-1:0]  r10_px, r10_py;
    logic                  r10_ok;

    always_ff @(posedge i_clk) begin
        r10_eax <= EW'(r9_ax) - EW'(r9_px);
        r10_eay <= EW'(r9_ay) - EW'(r9_py);
        r10_ebx <= EW'(r9_bx) - EW'(r9_px);
        r10_eby <= EW'(r9_by) - EW'(r9_py);
        r10_ax  <= r9_ax;
        r10_ay  <= r9_ay;
        r10_bx  <= r9_bx;
        r10_by  <= r9_by;
        r10_px  <= r9_px;
        r10_py  <= r9_py;
        r10_ok  <= r9_ok;
    end

    // ---- stage 11: squared offsets
    logic signed [DSW-1:0] c11_ax, c11_ay, c11_bx, c11_by;
    logic                  r11_vld;
    logic        [E2W-1:0] r11_sax, r11_say, r11_sbx, r11_sby;
    logic signed [PTW-1:0] r11_ax, r11_ay, r11_bx, r11_by;
    logic signed [CW-1:0]  r11_px, r11_py;
    logic                  r11_ok;

    assign c11_ax = r10_eax * r10_eax;
    assign c11_ay = r10_eay * r10_eay;
    assign c11_bx = r10_ebx * r10_ebx;
    assign c11_by = r10_eby * r10_eby;

    always_ff @(posedge i_clk) begin
        r11_sax <= c11_ax[E2W-1:0];
        r11_say <= c11_ay[E2W-1:0];
        r11_sbx <= c11_bx[E2W-1:0];
        r11_sby <= c11_by[E2W-1:0];
        r11_ax  <= r10_ax;
        r11_ay  <= r10_ay;
        r11_bx  <= r10_bx;
        r11_by  <= r10_by;
        r11_px  <= r10_px;
        r11_py  <= r10_py;
        r11_ok  <= r10_ok;
    end

    // ---- stage 12: squared distances
    logic                  r12_vld;
    logic        [DSW-1:0] r12_da, r12_db;
    logic signed [PTW-1:0] r12_ax, r12_ay, r12_bx, r12_by;
    logic signed [CW-1:0]  r12_px, r12_py;
    logic                  r12_ok;

    always_ff @(posedge i_clk) begin
        r12_da <= DSW'(r11_sax) + DSW'(r11_say);
        r12_db <= DSW'(r11_sbx) + DSW'(r11_sby);
        r12_ax <= r11_ax;
        r12_ay <= r11_ay;
        r12_bx <= r11_bx;
        r12_by <= r11_by;
        r12_px <= r11_px;
        r12_py <= r11_py;
        r12_ok <= r11_ok;
    end

    // ---- output stage: pick nearer point (B on tie), saturate
    logic signed [PTW-1:0] c_pick_x, c_pick_y;
    logic        [CW-1:0]  c_sat_x, c_sat_y;
    logic        [CW-1:0]  c_max, c_min;
    logic                  r_out_vld;
    logic signed [CW-1:0]  r_pos_x, r_pos_y;
    logic                  r_found;

    assign c_max = {1'b0, {(CW-1){1'b1}}};
    assign c_min = {1'b1, {(CW-1){1'b0}}};

    always_comb begin
        c_pick_x = (r12_da < r12_db) ? r12_ax : r12_bx;
        c_pick_y = (r12_da < r12_db) ? r12_ay : r12_by;
        if ((&c_pick_x[PTW-1:CW-1]) || !(|c_pick_x[PTW-1:CW-1])) begin
            c_sat_x = c_pick_x[CW-1:0];
        end else begin
            c_sat_x = c_pick_x[PTW-1] ? c_min : c_max;
        end
        if ((&c_pick_y[PTW-1:CW-1]) || !(|c_pick_y[PTW-1:CW-1])) begin
            c_sat_y = c_pick_y[CW-1:0];
        end else begin
            c_sat_y = c_pick_y[PTW-1] ? c_min : c_max;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos_x <= r12_ok ? c_sat_x : r12_px;
        r_pos_y <= r12_ok ? c_sat_y : r12_py;
        r_found <= r12_ok;
    end

    // ---- valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r5_vld    <= 1'b0;
            r6_vld    <= 1'b0;
            r7_vld    <= 1'b0;
            r8_vld    <= 1'b0;
            r9_vld    <= 1'b0;
            r10_vld   <= 1'b0;
            r11_vld   <= 1'b0;
            r12_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r1_vld    <= accept;
            r2_vld    <= r1_vld;
            r3_vld    <= r2_vld;
            r4_vld    <= r3_vld;
            r5_vld    <= r4_vld;
            r6_vld    <= sq_vld;
            r7_vld    <= r6_vld;
            r8_vld    <= r7_vld;
            r9_vld    <= &dv_vld;
            r10_vld   <= r9_vld;
            r11_vld   <= r10_vld;
            r12_vld   <= r11_vld;
            r_out_vld <= r12_vld;
        end
    end

    assign o_strobe = r_out_vld;
    assign o_pos_x  = r_pos_x;
    assign o_pos_y  = r_pos_y;
    assign o_found  = r_found;

    // ---- assertions
    a_beat_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_strobe)
        else $error("accepted beat produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LATENCY))
        else $error("result without matching input beat");

    a_prev_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_found) |->
            (o_pos_x == $past(i_prev_x, LATENCY)) && (o_pos_y == $past(i_prev_y, LATENCY)))
        else $error("previous position not returned on miss");

endmodule

// ===== design/tcl_isqrt.sv =====
module tcl_isqrt #(
    parameter int IN_W = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [IN_W-1:0]       i_value,
    output logic                  o_valid,
    output logic [IN_W/2-1:0]     o_root
);

    // One root bit per stage, restoring digit-by-digit method.
    localparam int OUT_W = IN_W / 2;
    localparam int NST   = OUT_W;
    localparam int REM_W = OUT_W + 1;
    localparam int T_W   = OUT_W + 3;

    logic [NST-1:0]   r_vld;
    logic [NST-1:0]   n_vld;
    logic [REM_W-1:0] r_rem  [NST];
    logic [REM_W-1:0] n_rem  [NST];
    logic [OUT_W-1:0] r_root [NST];
    logic [OUT_W-1:0] n_root [NST];
    logic [IN_W-1:0]  r_val  [NST];
    logic [IN_W-1:0]  n_val  [NST];

    always_comb begin
        logic             p_vld;
        logic [REM_W-1:0] p_rem;
        logic [OUT_W-1:0] p_root;
        logic [IN_W-1:0]  p_val;
        logic [T_W-1:0]   t;
        logic [T_W-1:0]   trial;
        for (int g = 0; g < NST; g++) begin
            if (g == 0) begin
                p_vld  = i_valid;
                p_rem  = '0;
                p_root = '0;
                p_val  = i_value;
            end else begin
                p_vld  = r_vld[g-1];
                p_rem  = r_rem[g-1];
                p_root = r_root[g-1];
                p_val  = r_val[g-1];
            end
            t        = {p_rem, p_val[IN_W-1 -: 2]};
            trial    = {1'b0, p_root, 2'b01};
            n_vld[g] = p_vld;
            n_val[g] = p_val << 2;
            if (t >= trial) begin
                n_rem[g]  = REM_W'(t - trial);
                n_root[g] = {p_root[OUT_W-2:0], 1'b1};
            end else begin
                n_rem[g]  = t[REM_W-1:0];
                n_root[g] = {p_root[OUT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_root <= n_root;
        r_val  <= n_val;
    end

    assign o_valid = r_vld[NST-1];
    assign o_root  = r_root[NST-1];

endmodule

// ===== design/tcl_rdiv.sv =====
module tcl_rdiv #(
    parameter int NUM_W = 51,
    parameter int DEN_W = 35,
    parameter int Q_W   = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_valid,
    output logic [Q_W-1:0]   o_quo
);

    // Restoring long division, one quotient bit per stage.
    // Caller guarantees the quotient fits in Q_W bits.
    logic [Q_W-1:0]   r_vld;
    logic [Q_W-1:0]   n_vld;
    logic [DEN_W-1:0] r_rem [Q_W];
    logic [DEN_W-1:0] n_rem [Q_W];
    logic [DEN_W-1:0] r_den [Q_W];
    logic [DEN_W-1:0] n_den [Q_W];
    logic [Q_W-1:0]   r_low [Q_W];
    logic [Q_W-1:0]   n_low [Q_W];
    logic [Q_W-1:0]   r_quo [Q_W];
    logic [Q_W-1:0]   n_quo [Q_W];

    always_comb begin
        logic             p_vld;
        logic [DEN_W-1:0] p_rem;
        logic [DEN_W-1:0] p_den;
        logic [Q_W-1:0]   p_low;
        logic [Q_W-1:0]   p_quo;
        logic [DEN_W:0]   t;
        for (int g = 0; g < Q_W; g++) begin
            if (g == 0) begin
                p_vld = i_valid;
                p_rem = DEN_W'(i_num >> Q_W);
                p_den = i_den;
                p_low = i_num[Q_W-1:0];
                p_quo = '0;
            end else begin
                p_vld = r_vld[g-1];
                p_rem = r_rem[g-1];
                p_den = r_den[g-1];
                p_low = r_low[g-1];
                p_quo = r_quo[g-1];
            end
            t        = {p_rem, p_low[Q_W-1]};
            n_vld[g] = p_vld;
            n_den[g] = p_den;
            n_low[g] = p_low << 1;
            if (t >= {1'b0, p_den}) begin
                n_rem[g] = DEN_W'(t - {1'b0, p_den});
                n_quo[g] = {p_quo[Q_W-2:0], 1'b1};
            end else begin
                n_rem[g] = t[DEN_W-1:0];
                n_quo[g] = {p_quo[Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= n_den;
        r_low <= n_low;
        r_quo <= n_quo;
    end

    assign o_valid = r_vld[Q_W-1];
    assign o_quo   = r_quo[Q_W-1];

endmodule
